// File: rtl/mhpq_pkg.sv
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_DRAIN  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [VAL_W-1:0] value;
    } req_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic                    out_valid;
        logic [1:0]              status;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } rsp_word_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t                op;
        logic signed [VAL_W-1:0] value;
    } cell_ctl_t;

endpackage

// File: rtl/mhpq_cell.sv
module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic                    occupied,
    input  logic signed [VAL_W-1:0] up_data,
    input  logic                    up_greater,
    input  logic signed [VAL_W-1:0] down_data,
    output logic signed [VAL_W-1:0] data,
    output logic                    greater
);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    // an empty cell ranks below any value
    assign greater = !occupied || (ctl.value > data_reg);
    assign data    = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (up_greater)
                begin
                    data_next = up_data;
                end
                else if (greater)
                begin
                    data_next = ctl.value;
                end
            end
            CELL_SHIFT:
            begin
                data_next = down_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: rtl/max_heap_priority_queue_top.sv
// Priority queue of signed 32-bit values, largest out first.
//
// Request channel (req_valid / req_stall / req): a word carries req_type and
// value. Insert adds value, remove takes the largest entry out, drain takes
// every entry out in descending order. Response channel (rsp_valid /
// rsp_stall / rsp) returns one word per request, or one word per entry for a
// drain of a non-empty queue, with last marking the final word.
//
// The entries live in a row of 64 cells kept sorted, largest in cell 0. An
// insert compares the new value in every cell at once and shifts the lower
// part down by one; a remove shifts the whole row up by one. Each response
// is registered and shows in the cycle after acceptance. A drain emits one
// word per entry, a new one whenever the response slot is free, and holds
// req_stall high until the last one is produced.
//
// A new request is taken while no drain runs and the response register is
// empty or its word is being taken in the same cycle. A held word stays while
// rsp_stall is high, and req_stall rises. Reset empties the queue and the
// response register; the cells keep stale data, never read past the count.
module max_heap_priority_queue_top
    import mhpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             drain_reg;
    logic             drain_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_word_t        rsp_reg;
    rsp_word_t        rsp_next;
    cell_ctl_t        ctl;

    logic                    slot_free;
    logic                    accept;
    logic signed [VAL_W-1:0] cell_data    [CAPACITY];
    logic                    cell_greater [CAPACITY];

    // response slot opens when empty or when its word leaves this cycle
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !slot_free || drain_reg;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [VAL_W-1:0] up_d;
            logic                    up_g;
            logic signed [VAL_W-1:0] down_d;

            if (gi == 0)
            begin : g_head
                assign up_d = cell_data[gi];
                assign up_g = 1'b0;
            end
            else
            begin : g_body
                assign up_d = cell_data[gi-1];
                assign up_g = cell_greater[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign down_d = cell_data[gi];
            end
            else
            begin : g_inner
                assign down_d = cell_data[gi+1];
            end

            mhpq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (CNT_W'(gi) < count_reg),
                .up_data    (up_d),
                .up_greater (up_g),
                .down_data  (down_d),
                .data       (cell_data[gi]),
                .greater    (cell_greater[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        drain_next     = drain_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ctl.op         = CELL_HOLD;
        ctl.value      = req.value;

        if (drain_reg)
        begin
            // drain in progress: pop one entry per free slot
            if (slot_free)
            begin
                ctl.op             = CELL_SHIFT;
                count_next         = count_reg - CNT_W'(1);
                drain_next         = (count_reg > CNT_W'(1));
                rsp_valid_next     = 1'b1;
                rsp_next.out_value = cell_data[0];
                rsp_next.out_valid = 1'b1;
                rsp_next.status    = ST_OK;
                rsp_next.count     = count_reg - CNT_W'(1);
                rsp_next.last      = (count_reg == CNT_W'(1));
            end
        end
        else if (accept)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.out_value = '0;
            rsp_next.out_valid = 1'b0;
            rsp_next.status    = ST_OK;
            rsp_next.count     = count_reg;
            rsp_next.last      = 1'b1;
            unique case (req_type_t'(req.req_type))
                REQ_INSERT:
                begin
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctl.op         = CELL_INSERT;
                        count_next     = count_reg + CNT_W'(1);
                        rsp_next.count = count_reg + CNT_W'(1);
                    end
                end
                REQ_REMOVE, REQ_DRAIN:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.op             = CELL_SHIFT;
                        count_next         = count_reg - CNT_W'(1);
                        rsp_next.out_value = cell_data[0];
                        rsp_next.out_valid = 1'b1;
                        rsp_next.count     = count_reg - CNT_W'(1);
                        if (req_type_t'(req.req_type) == REQ_DRAIN)
                        begin
                            drain_next    = (count_reg > CNT_W'(1));
                            rsp_next.last = (count_reg == CNT_W'(1));
                        end
                    end
                end
                REQ_NONE:
                begin
                    rsp_next.status = ST_OK;
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drain_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            drain_reg     <= drain_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule
